FILE: rtl/core/bpd_pkg.sv
// Shared constants and types for the burst preamble deframer.
package bpd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LIMIT_W    = 16;
    localparam int unsigned SKIP_W     = 17;
    localparam int unsigned LEN_W      = 17;
    localparam int unsigned FMT_W      = 2;

    localparam logic [31:0] SYNC_A     = 32'h0000_72F8;
    localparam logic [31:0] SYNC_B     = 32'h0000_1F4E;
    localparam logic [LIMIT_W-1:0] SKIP_LIMIT_RESET = 16'd24576;
    localparam logic signed [LEN_W-1:0] LEN_OFFSET  = 17'sd16;
    localparam logic signed [LEN_W-1:0] WORD_BYTES  = 17'sd4;

    typedef enum logic [FMT_W-1:0]
    {
        FMT_UNKNOWN    = 2'd0,
        FMT_PCM        = 2'd1,
        FMT_COMPRESSED = 2'd2
    } format_t;

    // One result word as produced by the parser.
    typedef struct packed
    {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              burst_end;
        format_t           detected_format;
    } result_t;

endpackage

FILE: rtl/core/burst_preamble_deframer.sv
// Burst preamble deframer top level: limit register, input handshake, result register.
// An accepted byte's result word is in the output register in the cycle after its acceptance.
// Throughput: one byte per cycle while the input is not stalled; the parse state updates in the accept cycle.
// The input stalls only while a held result word is itself stalled downstream.
// Reset clears the parse state, the result register and sets skip_limit to 24576.
module burst_preamble_deframer import bpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               skip_limit_we,
    input  logic [LIMIT_W-1:0] skip_limit_data,
    input  logic               data_valid,
    output logic               data_stall,
    input  logic [BYTE_W-1:0]  data_byte,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               out_valid,
    output logic [BYTE_W-1:0]  out_byte,
    output logic               burst_end,
    output logic [FMT_W-1:0]   detected_format
);

    logic [LIMIT_W-1:0] skip_limit_reg;
    logic               res_valid_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               accept;

    // Take a new byte whenever the result register is free or draining
    assign data_stall = res_valid_reg && res_stall;
    assign accept     = data_valid && !data_stall;

    bpd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .data_byte  (data_byte),
        .skip_limit (skip_limit_reg),
        .result     (res_next)
    );

    // Hold the skip limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_limit_reg <= SKIP_LIMIT_RESET;
        end
        else if (skip_limit_we)
        begin
            skip_limit_reg <= skip_limit_data;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign out_valid       = res_reg.out_valid;
    assign out_byte        = res_reg.out_byte;
    assign burst_end       = res_reg.burst_end;
    assign detected_format = res_reg.detected_format;

    // Checks
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted word produced no result");

    a_end_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && burst_end) |-> out_valid)
        else $error("burst end flagged on a non-payload word");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_valid) |-> (out_byte == '0))
        else $error("non-payload word carries a byte");

    a_format_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (detected_format != 2'd3))
        else $error("illegal format verdict");

endmodule

FILE: rtl/core/bpd_parser.sv
// Byte-serial parse state machine: preamble hunt, header decode, payload extraction.
module bpd_parser import bpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [LIMIT_W-1:0] skip_limit,
    output result_t            result
);

    typedef enum logic [2:0]
    {
        PH_HUNT    = 3'd0,
        PH_SYNC_B  = 3'd1,
        PH_SKIP    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [31:0]               window_reg, window_next;
    logic [2:0]                fill_reg, fill_next;
    logic [1:0]                biw_reg, biw_next;
    logic signed [LEN_W-1:0]   rem_reg, rem_next;
    logic [SKIP_W-1:0]         skip_reg, skip_next;
    format_t                   verdict_reg, verdict_next;

    logic                      word_done;
    logic                      do_test;
    logic [15:0]               len_field;
    logic signed [LEN_W-1:0]   rem_dec;

    // Next state and result for the byte at the input
    always_comb
    begin
        window_next  = {window_reg[23:0], data_byte};
        word_done    = (biw_reg == 2'd3);
        len_field    = {window_next[7:0], window_next[15:8]};
        rem_dec      = rem_reg - WORD_BYTES;
        phase_next   = phase_reg;
        fill_next    = fill_reg;
        biw_next     = biw_reg;
        rem_next     = rem_reg;
        skip_next    = skip_reg;
        verdict_next = verdict_reg;
        do_test      = 1'b0;
        result.out_valid = 1'b0;
        result.out_byte  = '0;
        result.burst_end = 1'b0;

        unique case (phase_reg)
            PH_SYNC_B:
            begin
                if (word_done)
                begin
                    biw_next = 2'd0;
                    if (window_next == SYNC_B)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        // retest these four bytes as a first preamble
                        phase_next = PH_HUNT;
                        do_test    = 1'b1;
                    end
                end
                else
                begin
                    biw_next = biw_reg + 2'd1;
                end
            end
            PH_SKIP:
            begin
                if (word_done)
                begin
                    biw_next   = 2'd0;
                    phase_next = PH_LEN;
                end
                else
                begin
                    biw_next = biw_reg + 2'd1;
                end
            end
            PH_LEN:
            begin
                if (word_done)
                begin
                    rem_next     = $signed({1'b0, len_field}) - LEN_OFFSET;
                    skip_next    = '0;
                    verdict_next = FMT_COMPRESSED;
                    biw_next     = 2'd0;
                    phase_next   = PH_PAYLOAD;
                end
                else
                begin
                    biw_next = biw_reg + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                // bytes 2 and 3 of each word carry payload
                if (biw_reg[1])
                begin
                    result.out_valid = 1'b1;
                    result.out_byte  = data_byte;
                end
                if (word_done)
                begin
                    biw_next = 2'd0;
                    rem_next = rem_dec;
                    if (rem_dec <= 0)
                    begin
                        rem_next         = '0;
                        result.burst_end = 1'b1;
                        phase_next       = PH_HUNT;
                        fill_next        = 3'd0;
                    end
                end
                else
                begin
                    biw_next = biw_reg + 2'd1;
                end
            end
            default:
            begin
                // hunt, also for unused phase codes
                phase_next = PH_HUNT;
                if (fill_reg < 3'd4)
                begin
                    fill_next = fill_reg + 3'd1;
                end
                do_test = (fill_next >= 3'd4);
            end
        endcase

        // Test the full window against the first preamble word
        if (do_test)
        begin
            if (window_next == SYNC_A)
            begin
                phase_next = PH_SYNC_B;
                biw_next   = 2'd0;
                fill_next  = 3'd0;
            end
            else
            begin
                if (skip_reg != '1)
                begin
                    skip_next = skip_reg + 1'b1;
                end
                if (skip_next > {1'b0, skip_limit})
                begin
                    verdict_next = FMT_PCM;
                end
                fill_next = 3'd4;
            end
        end

        result.detected_format = verdict_next;
    end

    // Hold parse state; advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            window_reg  <= '0;
            fill_reg    <= '0;
            biw_reg     <= '0;
            rem_reg     <= '0;
            skip_reg    <= '0;
            verdict_reg <= FMT_UNKNOWN;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            window_reg  <= window_next;
            fill_reg    <= fill_next;
            biw_reg     <= biw_next;
            rem_reg     <= rem_next;
            skip_reg    <= skip_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule
